// ----- src/swa_pkg.sv -----
// shared types for the sliding window average block
`default_nettype none

package swa_pkg;

	// status of the iterative divider towards its sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- src/sliding_window_average_top.sv -----
// sliding window average: top level with ring store, running sum and sequencer
//
// moving average of signed samples over the last window_size requests
// input channel: sample with in_valid / in_ready, taken when both are high
// output channel: average with out_valid / out_ready, one result per request
// configuration: cfg_we writes cfg_wdata as window_size in the same cycle;
//   zero acts as a window of one, values above WINDOW_MAX saturate, and a write empties
//   the window so averaging starts again, unless the sum update state overrides it
// while the window fills the result is the mean of all samples so far
// timing: after acceptance a request passes the sum update, divider start, divide
//   and output states; in_ready returns in the same cycle as out_valid
// the restoring divider gives one quotient bit per cycle over the SUM_W-bit
//   running sum, after store read and sum update and before hand-over
// one request at a time: in_ready is low from acceptance until the result is
//   loaded into the output register
// a finished result waits in the output register; while it is stalled the
//   next request may already be accepted and worked on, and only its final
//   hand-over waits for out_ready
// reset: window_size returns to 4 (or WINDOW_MAX if smaller), sum, fill count
//   and ring pointer clear; an old ring value enters the sum only once the window is full
`default_nettype none

module sliding_window_average_top #(
	parameter int WINDOW_MAX  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [8:0]                    cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      average
);
	import swa_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
	localparam logic [CNT_W-1:0] RESET_WIN = CNT_W'((WINDOW_MAX < 4) ? WINDOW_MAX : 4);

	// one-hot sequencer
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_UPD   = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]              win_q;
	logic [CNT_W-1:0]              fill_q;
	logic [SLOT_W-1:0]             wslot_q;
	logic signed [SUM_W-1:0]       sum_q;

	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic [SLOT_W-1:0]             cur_slot_q;
	logic signed [SAMPLE_BITS-1:0] hist_q [WINDOW_MAX];

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] average_q;

	logic                          accept;
	logic [CNT_W-1:0]              cfg_win;
	logic [SLOT_W-1:0]             slot_sel;
	logic [CNT_W-1:0]              slot_nxt;
	logic                          full;
	logic signed [SUM_W-1:0]       smp_ext;
	logic signed [SUM_W-1:0]       old_ext;
	logic signed [SAMPLE_BITS-1:0] div_q;
	div_stat_t                     div_stat;
	logic                          out_load;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// window size as written, clamped to 1..WINDOW_MAX
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_win = CNT_W'(1);
		end else if (int'(cfg_wdata) > WINDOW_MAX) begin
			cfg_win = CNT_W'(WINDOW_MAX);
		end else begin
			cfg_win = CNT_W'(cfg_wdata);
		end
	end

	// slot to overwrite, wrapped if the window shrank
	assign slot_sel = (CNT_W'(wslot_q) >= win_q) ? '0 : wslot_q;
	assign slot_nxt = CNT_W'(cur_slot_q) + CNT_W'(1);
	assign full     = (fill_q >= win_q);
	assign smp_ext  = {{(SUM_W-SAMPLE_BITS){smp_q[SAMPLE_BITS-1]}}, smp_q};
	assign old_ext  = full ? {{(SUM_W-SAMPLE_BITS){old_q[SAMPLE_BITS-1]}}, old_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_q   <= RESET_WIN;
			fill_q  <= '0;
			wslot_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cfg_we) begin
				win_q   <= cfg_win;
				fill_q  <= '0;
				wslot_q <= '0;
				sum_q   <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// drop the oldest sample once the window is full
					sum_q   <= sum_q + smp_ext - old_ext;
					wslot_q <= (slot_nxt >= win_q) ? '0 : SLOT_W'(slot_nxt);
					if (!full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ring store, registered read of the slot about to be replaced
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q      <= sample;
			cur_slot_q <= slot_sel;
			old_q      <= hist_q[slot_sel];
		end
		if (state_q == ST_UPD) begin
			hist_q[cur_slot_q] <= smp_q;
		end
	end

	swa_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W),
		.Q_W   (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_START),
		.dividend (sum_q),
		.divisor  (fill_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	// output register
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			average_q <= div_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

endmodule

`default_nettype wire

// ----- src/swa_div.sv -----
// iterative restoring divider, signed dividend by positive divisor, one quotient bit per cycle
`default_nettype none

module swa_div #(
	parameter int DVD_W = 24,
	parameter int DVS_W = 9,
	parameter int Q_W   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [DVD_W-1:0] dividend,
	input  wire logic        [DVS_W-1:0] divisor,
	output logic signed      [Q_W-1:0]   quotient,
	output swa_pkg::div_stat_t           stat
);
	import swa_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   dvs_ext;
	logic             fits;
	logic [DVD_W-1:0] quo_signed;

	assign rem_sh  = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
	assign dvs_ext = {1'b0, dvs_q};
	assign fits    = (rem_sh >= dvs_ext);

	// restore the sign of the magnitude quotient
	assign quo_signed = neg_q ? (~quo_q + DVD_W'(1)) : quo_q;
	assign quotient   = Q_W'(quo_signed);

	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[DVD_W-1] ? (~dividend + DVD_W'(1)) : dividend;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - dvs_ext) : rem_sh;
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// ----- src/swa_checker.sv -----
// port-level checks for the sliding window average, bound to the top level
`default_nettype none

module swa_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] average
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average))
		else $error("stalled result changed");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// a busy block cannot free up while its output is stalled
	a_no_free_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_valid && !out_ready |=> !in_ready)
		else $error("ready returned with result still blocked");

	// the result of a request cannot appear right after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind sliding_window_average_top swa_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.average   (average)
);

`default_nettype wire
